// ===== sv/sle_pkg.sv =====
// sle_pkg: shared types and constants of the serial line editor
package sle_pkg;

    localparam int unsigned ACT_W  = 3;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LIM_W  = 7;
    localparam int unsigned MODE_W = 2;

    localparam logic [ACT_W-1:0] ACT_ECHO     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ERASE    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REPROMPT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_LINE     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_OVERFLOW = 3'd4;

    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ESC    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CSI    = 2'd2;

    localparam logic [BYTE_W-1:0] CH_NUL  = 8'h00;
    localparam logic [BYTE_W-1:0] CH_BS   = 8'h08;
    localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_ESC  = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_DEL  = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_LBRK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_LC_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LC_Z = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_UC_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UC_Z = 8'h5A;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 7'd64;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD   = 4'b0010,
        ST_LINE = 4'b0100,
        ST_OVF  = 4'b1000
    } sle_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic load_line;
        logic load_ovf;
        logic idx_inc;
        logic dump_done;
    } sle_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic dump_start;
        logic ovf_start;
        logic last_idx;
    } sle_status_t;

endpackage

// ===== sv/serial_line_editor_unit.sv =====
// serial_line_editor_unit: top level of the serial line editor
//
// s_* carries received terminal bytes, one byte per transaction.
// m_* carries editor results: action and data byte in m_tdata, m_tlast
// marks the final result caused by one input byte.
// cfg_* writes the line limit (count at which the line is discarded).
// An ordinary byte, reprompt, or backspace on a non-empty line gives one
// result, registered on acceptance; the next byte can be taken in
// the following cycle if the receiver takes it. A stored byte that reaches
// the limit gives echo then overflow. Carriage return on a non-empty line
// streams it byte by byte (store read, then output load), up to LINE_MAX-1
// bytes; no byte is accepted until the stream ends.
// Reset clears edit mode, count and stream index, sets the limit to 64 and
// empties the output register; the line store itself is not cleared.
// When the receiver stalls, the result holds in the output register and
// s_tready drops until it can take the next result.
module serial_line_editor_unit
    import sle_pkg::*;
#(
    parameter int unsigned LINE_MAX = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // [2:0] action, [10:3] data_byte, [15:11] zero
    output logic             m_tlast,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [LIM_W-1:0] cfg_data   // [6:0] line_limit
);

    sle_cmd_t          cmd;
    sle_status_t       st;
    logic [ACT_W-1:0]  m_action;
    logic [BYTE_W-1:0] m_data_byte;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {5'd0, m_data_byte, m_action};

    sle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    sle_datapath #(
        .LINE_MAX (LINE_MAX)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rx_byte     (s_tdata),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .st          (st),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_action    (m_action),
        .m_data_byte (m_data_byte),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== sv/sle_ctrl.sv =====
// sle_ctrl: sequencing of input acceptance, line streaming and overflow report
module sle_ctrl
    import sle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  sle_status_t st,
    output sle_cmd_t    cmd
);

    sle_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = st.out_free;
                cmd.accept = s_tvalid && st.out_free;
                if (cmd.accept && st.dump_start) begin
                    state_next = ST_RD;
                end else if (cmd.accept && st.ovf_start) begin
                    state_next = ST_OVF;
                end
            end
            ST_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_LINE;
            end
            ST_LINE: begin
                if (st.out_free) begin
                    cmd.load_line = 1'b1;
                    if (st.last_idx) begin
                        cmd.dump_done = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_RD;
                    end
                end
            end
            ST_OVF: begin
                if (st.out_free) begin
                    cmd.load_ovf = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/sle_datapath.sv =====
// sle_datapath: edit mode, character count, line store and output register
module sle_datapath
    import sle_pkg::*;
#(
    parameter int unsigned LINE_MAX = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              cfg_wr,
    input  logic [LIM_W-1:0]  cfg_data,
    input  sle_cmd_t          cmd,
    output sle_status_t       st,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [ACT_W-1:0]  m_action,
    output logic [BYTE_W-1:0] m_data_byte,
    output logic              m_tlast
);

    localparam int unsigned IW = $clog2(LINE_MAX);
    localparam int unsigned CW = $clog2(LINE_MAX + 1);
    localparam logic [LIM_W-1:0] LIMIT_MAX = LIM_W'(LINE_MAX);

    logic [BYTE_W-1:0] line_mem [LINE_MAX];
    logic [BYTE_W-1:0] rd_data_reg;

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [LIM_W-1:0]  limit_reg;

    logic              out_valid_reg, out_valid_next;
    logic [ACT_W-1:0]  out_act_reg, out_act_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    logic              in_seq;
    logic              is_letter;
    logic              store_en;
    logic [CW-1:0]     count_inc;
    logic [LIM_W-1:0]  eff_limit;
    logic              hit_limit;

    assign in_seq    = (mode_reg == MODE_ESC) || (mode_reg == MODE_CSI);
    assign is_letter = ((rx_byte >= CH_LC_A) && (rx_byte <= CH_LC_Z)) ||
                       ((rx_byte >= CH_UC_A) && (rx_byte <= CH_UC_Z));
    assign store_en  = !in_seq && (rx_byte != CH_CR) && (rx_byte != CH_BS) &&
                       (rx_byte != CH_DEL) && (rx_byte != CH_ESC) && (rx_byte != CH_NUL);
    assign count_inc = count_reg + CW'(1);

    always_comb begin
        priority if (limit_reg == '0) begin
            eff_limit = LIM_W'(1);
        end else if (limit_reg > LIMIT_MAX) begin
            eff_limit = LIMIT_MAX;
        end else begin
            eff_limit = limit_reg;
        end
    end

    assign hit_limit = LIM_W'(count_inc) >= eff_limit;

    assign st.out_free   = !out_valid_reg || m_tready;
    assign st.dump_start = !in_seq && (rx_byte == CH_CR) && (count_reg != '0);
    assign st.ovf_start  = store_en && hit_limit;
    assign st.last_idx   = (CW'(idx_reg) + CW'(1)) == count_reg;

    always_comb begin
        mode_next      = mode_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_act_next   = out_act_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (cmd.accept) begin
            priority if (in_seq) begin
                if (rx_byte == CH_LBRK) begin
                    mode_next = MODE_CSI;
                end else if (is_letter || (mode_reg == MODE_ESC)) begin
                    mode_next = MODE_NORMAL;
                end
            end else if (rx_byte == CH_CR) begin
                // a non-empty line is streamed by the controller
                if (count_reg == '0) begin
                    out_valid_next = 1'b1;
                    out_act_next   = ACT_REPROMPT;
                    out_data_next  = '0;
                    out_last_next  = 1'b1;
                end
            end else if ((rx_byte == CH_BS) || (rx_byte == CH_DEL)) begin
                if (count_reg != '0) begin
                    count_next     = count_reg - CW'(1);
                    out_valid_next = 1'b1;
                    out_act_next   = ACT_ERASE;
                    out_data_next  = '0;
                    out_last_next  = 1'b1;
                end
            end else if (rx_byte == CH_ESC) begin
                mode_next = MODE_ESC;
            end else if (rx_byte == CH_NUL) begin
                mode_next = mode_reg;
            end else begin
                out_valid_next = 1'b1;
                out_act_next   = ACT_ECHO;
                out_data_next  = rx_byte;
                out_last_next  = !hit_limit;
                count_next     = hit_limit ? '0 : count_inc;
            end
        end

        if (cmd.load_line) begin
            out_valid_next = 1'b1;
            out_act_next   = ACT_LINE;
            out_data_next  = rd_data_reg;
            out_last_next  = st.last_idx;
        end

        if (cmd.load_ovf) begin
            out_valid_next = 1'b1;
            out_act_next   = ACT_OVERFLOW;
            out_data_next  = '0;
            out_last_next  = 1'b1;
        end

        if (cmd.idx_inc) begin
            idx_next = idx_reg + IW'(1);
        end

        if (cmd.dump_done) begin
            idx_next   = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_NORMAL;
            count_reg     <= '0;
            idx_reg       <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr) begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_act_reg  <= out_act_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // count stays below LINE_MAX whenever a byte is stored
    always_ff @(posedge aclk) begin
        if (cmd.accept && store_en) begin
            line_mem[count_reg[IW-1:0]] <= rx_byte;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= line_mem[idx_reg];
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign m_action    = out_act_reg;
    assign m_data_byte = out_data_reg;
    assign m_tlast     = out_last_reg;

endmodule

// ===== test/serial_line_editor_unit_test.sv =====
// serial_line_editor_unit_test: self-checking testbench of the serial line editor unit
`timescale 1ns / 100ps

module serial_line_editor_unit_test;
    import sle_pkg::*;

    localparam int unsigned LINE_CAP = 64;
    localparam int unsigned MAX_LOG  = 10;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } edit_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = '0;   // [7:0] rx_byte
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [15:0]      m_tdata;        // [2:0] action, [10:3] data_byte, [15:11] zero
    logic             m_tlast;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [LIM_W-1:0] cfg_data = '0;  // [6:0] line_limit

    // terminal bytes waiting to be sent, results the editor still owes
    logic [7:0]   typed_bytes[$];
    edit_result_t owed_results[$];

    // editor state as predicted
    logic [MODE_W-1:0] mode_q = MODE_NORMAL;
    logic [6:0]        count_q = '0;
    logic [7:0]        line_q[LINE_CAP];
    logic [LIM_W-1:0]  limit_q = LIMIT_RESET;

    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    logic byte_taken = 1'b0;

    int mismatches = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int lines_sent = 0;
    int overflows = 0;
    int limits_written = 0;

    serial_line_editor_unit #(
        .LINE_MAX(LINE_CAP)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    // works out the results of one received byte and updates the editor state
    task automatic edit_byte(input logic [7:0] b);
        int unsigned lim;
        if (mode_q == MODE_ESC || mode_q == MODE_CSI) begin
            if (b == CH_LBRK) begin
                mode_q = MODE_CSI;
            end else if ((b >= CH_LC_A && b <= CH_LC_Z) || (b >= CH_UC_A && b <= CH_UC_Z)
                         || mode_q == MODE_ESC) begin
                mode_q = MODE_NORMAL;
            end
        end else if (b == CH_CR) begin
            if (count_q > 0) begin
                for (int i = 0; i < count_q; i++)
                    owed_results.push_back('{ACT_LINE, line_q[i], (i + 1 == count_q)});
                count_q = '0;
                lines_sent++;
            end else begin
                owed_results.push_back('{ACT_REPROMPT, 8'h00, 1'b1});
            end
        end else if (b == CH_BS || b == CH_DEL) begin
            if (count_q > 0) begin
                count_q--;
                owed_results.push_back('{ACT_ERASE, 8'h00, 1'b1});
            end
        end else if (b == CH_ESC) begin
            mode_q = MODE_ESC;
        end else if (b != CH_NUL) begin
            if (count_q < LINE_CAP)
                line_q[count_q] = b;
            count_q++;
            lim = limit_q;
            if (lim < 1) lim = 1;
            if (lim > LINE_CAP) lim = LINE_CAP;
            if (count_q >= lim) begin
                count_q = '0;
                owed_results.push_back('{ACT_ECHO, b, 1'b0});
                owed_results.push_back('{ACT_OVERFLOW, 8'h00, 1'b1});
                overflows++;
            end else begin
                owed_results.push_back('{ACT_ECHO, b, 1'b1});
            end
        end
    endtask

    task automatic compare_result();
        edit_result_t want;
        logic [15:0]  want_data;
        results_seen++;
        if (owed_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_LOG)
                $display("%0t: unexpected result, action %0d data %02h last %0b",
                         $time, m_tdata[2:0], m_tdata[10:3], m_tlast);
        end else begin
            want = owed_results.pop_front();
            want_data = {5'b0, want.data_byte, want.action};
            if (m_tdata !== want_data || m_tlast !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_LOG)
                    $display({"%0t: result %0d: expected action %0d data %02h last %0b,",
                              " got action %0d data %02h last %0b pad %02h"},
                             $time, results_seen, want.action, want.data_byte, want.last,
                             m_tdata[2:0], m_tdata[10:3], m_tlast, m_tdata[15:11]);
            end
        end
    endtask

    // monitor: checks results and tracks every accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            byte_taken <= 1'b0;
        end else begin
            byte_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
                compare_result();
            if (cfg_valid && cfg_ready)
                limit_q = cfg_data;
            if (s_tvalid && s_tready) begin
                bytes_sent++;
                edit_byte(s_tdata);
            end
        end
    end

    // driver: feeds typed bytes with random gaps
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || byte_taken)) begin
            if (typed_bytes.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
                s_tdata <= typed_bytes.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= rcv_stall_pct);

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        if ($urandom_range(9) < 7)
            b = 8'($urandom_range(8'h20, 8'h7E));
        else
            b = 8'($urandom_range(1, 255));
        if (b == CH_CR || b == CH_BS || b == CH_DEL || b == CH_ESC)
            b = 8'h2E;
        return b;
    endfunction

    function automatic logic [7:0] letter_byte();
        if ($urandom_range(1))
            return CH_UC_A + 8'($urandom_range(25));
        return CH_LC_A + 8'($urandom_range(25));
    endfunction

    task automatic type_run(input int n);
        repeat (n) typed_bytes.push_back(plain_byte());
    endtask

    // mostly typed words, edits and escape sequences, some raw noise
    task automatic random_traffic(input int n);
        int goal;
        int pick;
        goal = typed_bytes.size() + n;
        while (typed_bytes.size() < goal) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                type_run($urandom_range(1, 8));
                if ($urandom_range(1))
                    typed_bytes.push_back(CH_CR);
            end else if (pick < 68) begin
                typed_bytes.push_back($urandom_range(1) ? CH_BS : CH_DEL);
            end else if (pick < 82) begin
                typed_bytes.push_back(CH_ESC);
                if ($urandom_range(2) == 0) begin
                    typed_bytes.push_back(8'($urandom_range(255)));
                end else begin
                    typed_bytes.push_back(CH_LBRK);
                    repeat ($urandom_range(3))
                        typed_bytes.push_back($urandom_range(3) ? 8'($urandom_range(8'h30, 8'h3B))
                                                                : CH_LBRK);
                    typed_bytes.push_back(letter_byte());
                end
            end else if (pick < 90) begin
                typed_bytes.push_back(CH_CR);
            end else begin
                typed_bytes.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    // wait until the editor has drained, then let a full stream time pass
    task automatic settle();
        while (typed_bytes.size() != 0 || s_tvalid || owed_results.size() != 0)
            @(posedge aclk);
        repeat (2 * LINE_CAP + 4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        limits_written++;
    endtask

    initial begin
        logic [7:0] opening[$];
        opening = '{CH_CR, CH_BS, CH_DEL, CH_NUL, CH_LC_A, 8'hFF, 8'h80, 8'h01, CH_BS, CH_DEL,
                    8'h7E, CH_CR, CH_ESC, 8'h7B, CH_ESC, CH_LBRK, 8'h31, CH_LBRK, 8'h3B,
                    CH_UC_Z, CH_ESC, CH_LBRK, CH_LC_A, CH_ESC, CH_ESC, CH_UC_A, CH_CR};
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        snd_idle_pct = 38;
        rcv_stall_pct = 50;
        foreach (opening[i]) typed_bytes.push_back(opening[i]);
        // longest possible line streamed out
        type_run(LINE_CAP - 1);
        typed_bytes.push_back(CH_CR);
        settle();

        write_limit(LIMIT_RESET);
        type_run(LINE_CAP);
        // leave a partial line so the next lower limit cuts below the count
        type_run(5);
        settle();

        snd_idle_pct = 50;
        rcv_stall_pct = 38;
        write_limit(7'd1);
        random_traffic(30);
        settle();
        write_limit(7'($urandom_range(2, 16)));
        random_traffic(50);
        settle();

        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        write_limit(7'd2);
        random_traffic(30);
        settle();
        write_limit(LIMIT_RESET);
        random_traffic(50);
        settle();

        $display("sent %0d terminal bytes over %0d limit writes, checked %0d results",
                 bytes_sent, limits_written, results_seen);
        $display("streamed %0d lines, %0d overflows, %0d mismatches",
                 lines_sent, overflows, mismatches);
        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d results still owed", owed_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
